// ===== src/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the sliding-window statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SWMM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/swmm_pkg.sv =====
// Types, constants and the microcode table of the sliding-window statistics block.
package swmm_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CNT_W     = 11;
    localparam int SUM_W     = SAMPLE_W + CNT_W;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int PC_W      = 3;

    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(1000);

    // Program steps
    localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] STEP_ISSUE = 3'd1;
    localparam logic [PC_W-1:0] STEP_SCAN  = 3'd2;
    localparam logic [PC_W-1:0] STEP_DIV0  = 3'd3;
    localparam logic [PC_W-1:0] STEP_DIV   = 3'd4;
    localparam logic [PC_W-1:0] STEP_HOLD  = 3'd5;
    localparam logic [PC_W-1:0] STEP_POST  = 3'd6;

    typedef enum logic [2:0] {
        JC_NEVER      = 3'd0,
        JC_NO_INPUT   = 3'd1,
        JC_MORE_READS = 3'd2,
        JC_DIV_MORE   = 3'd3,
        JC_OUT_BUSY   = 3'd4,
        JC_ALWAYS     = 3'd5
    } jc_t;

    typedef struct packed {
        logic            load;
        logic            rd_issue;
        logic            acc;
        logic            div_init;
        logic            div_step;
        logic            out_load;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic more_reads;
        logic div_more;
        logic out_busy;
    } stat_t;

    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t c;
        c        = '0;
        c.jc     = JC_NEVER;
        c.target = STEP_WAIT;
        case (pc)
            STEP_WAIT: begin
                c.load   = 1'b1;
                c.jc     = JC_NO_INPUT;
                c.target = STEP_WAIT;
            end
            STEP_ISSUE: begin
                c.rd_issue = 1'b1;
            end
            STEP_SCAN: begin
                c.rd_issue = 1'b1;
                c.acc      = 1'b1;
                c.jc       = JC_MORE_READS;
                c.target   = STEP_SCAN;
            end
            STEP_DIV0: begin
                c.div_init = 1'b1;
            end
            STEP_DIV: begin
                c.div_step = 1'b1;
                c.jc       = JC_DIV_MORE;
                c.target   = STEP_DIV;
            end
            STEP_HOLD: begin
                c.jc     = JC_OUT_BUSY;
                c.target = STEP_HOLD;
            end
            STEP_POST: begin
                c.out_load = 1'b1;
                c.jc       = JC_ALWAYS;
                c.target   = STEP_WAIT;
            end
            default: begin
                c.jc     = JC_ALWAYS;
                c.target = STEP_WAIT;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== src/sliding_window_min_max_mean.sv =====
// Top level of the sliding-window minimum, maximum and mean block.
// Each sample transfer writes the sample into a DEPTH-entry ring store and yields one result:
// min, max and truncated mean over the newest held_count samples, where held_count grows by
// one per sample up to the window length (window_len, 0 acts as 1, capped at DEPTH). After a
// transfer, the scan reads the store one entry per cycle through its single read port, then
// a radix-2 divider works out the mean. The next sample is taken as soon as the result sits
// in the output register, even while that result still waits for m_ready; a result that is
// still waiting when the next one is ready adds its stall. Store entries need no clearing
// after reset.
`include "assert_macros.svh"

module sliding_window_min_max_mean #(
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [swmm_pkg::CNT_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] m_window_min,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] m_window_max,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] m_window_mean,
    output logic [swmm_pkg::CNT_W-1:0]           m_held_count
);

    localparam logic [swmm_pkg::CNT_W-1:0] DEPTH_CAP =
        (DEPTH > int'(swmm_pkg::CNT_MAX)) ? swmm_pkg::CNT_MAX : swmm_pkg::CNT_W'(DEPTH);

    swmm_pkg::ctl_t  ctl;
    swmm_pkg::stat_t stat;

    logic [swmm_pkg::CNT_W-1:0]           window_len_reg;
    logic [swmm_pkg::CNT_W-1:0]           win;
    logic                                 in_fire;
    logic [swmm_pkg::CNT_W-1:0]           fill;
    logic signed [swmm_pkg::SAMPLE_W-1:0] win_min;
    logic signed [swmm_pkg::SAMPLE_W-1:0] win_max;
    logic signed [swmm_pkg::SUM_W-1:0]    sum;
    logic signed [swmm_pkg::SAMPLE_W-1:0] mean;
    logic                                 more_reads;
    logic                                 div_more;

    logic                                 m_valid_reg;
    logic signed [swmm_pkg::SAMPLE_W-1:0] min_out_reg;
    logic signed [swmm_pkg::SAMPLE_W-1:0] max_out_reg;
    logic signed [swmm_pkg::SAMPLE_W-1:0] mean_out_reg;
    logic [swmm_pkg::CNT_W-1:0]           count_out_reg;

    assign win = (window_len_reg == '0)       ? swmm_pkg::CNT_W'(1) :
                 (window_len_reg > DEPTH_CAP) ? DEPTH_CAP : window_len_reg;

    assign s_ready = ctl.load;
    assign in_fire = s_valid && s_ready;

    assign stat.in_valid   = s_valid;
    assign stat.more_reads = more_reads;
    assign stat.div_more   = div_more;
    assign stat.out_busy   = m_valid_reg && !m_ready;

    swmm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    swmm_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .in_fire    (in_fire),
        .sample     (s_sample),
        .win        (win),
        .fill       (fill),
        .win_min    (win_min),
        .win_max    (win_max),
        .sum        (sum),
        .more_reads (more_reads)
    );

    swmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .init     (ctl.div_init),
        .step     (ctl.div_step),
        .dividend (sum),
        .divisor  (fill),
        .quotient (mean),
        .more     (div_more)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= swmm_pkg::WINDOW_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_len_reg <= cfg_wr_data;
            end
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output register, loaded only once the previous result has gone
    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            min_out_reg   <= win_min;
            max_out_reg   <= win_max;
            mean_out_reg  <= mean;
            count_out_reg <= fill;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_window_min  = min_out_reg;
    assign m_window_max  = max_out_reg;
    assign m_window_mean = mean_out_reg;
    assign m_held_count  = count_out_reg;

    `SWMM_ASSERT_SAME(a_count_nonzero, m_valid, m_held_count != '0, "empty window reported")
    `SWMM_ASSERT_SAME(a_count_capped, m_valid, m_held_count <= DEPTH_CAP, "count beyond store")
    `SWMM_ASSERT_SAME(a_min_le_max, m_valid, m_window_min <= m_window_max, "min above max")
    `SWMM_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "sample taken mid-scan")

endmodule

// ===== src/swmm_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module swmm_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swmm_pkg::stat_t       stat,
    output swmm_pkg::ctl_t        ctl
);

    logic [swmm_pkg::PC_W-1:0] pc_reg;
    logic [swmm_pkg::PC_W-1:0] pc_next;
    logic                      jump;

    assign ctl = swmm_pkg::ucode(pc_reg);

    always_comb begin
        case (ctl.jc)
            swmm_pkg::JC_NEVER:      jump = 1'b0;
            swmm_pkg::JC_NO_INPUT:   jump = !stat.in_valid;
            swmm_pkg::JC_MORE_READS: jump = stat.more_reads;
            swmm_pkg::JC_DIV_MORE:   jump = stat.div_more;
            swmm_pkg::JC_OUT_BUSY:   jump = stat.out_busy;
            swmm_pkg::JC_ALWAYS:     jump = 1'b1;
            default:                 jump = 1'b1;
        endcase
        pc_next = jump ? ctl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= swmm_pkg::STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== src/swmm_scan.sv =====
// Sample ring store and the window scan for minimum, maximum and sum.
module swmm_scan #(
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  swmm_pkg::ctl_t                       ctl,
    input  logic                                 in_fire,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
    input  logic [swmm_pkg::CNT_W-1:0]           win,
    output logic [swmm_pkg::CNT_W-1:0]           fill,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] win_min,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] win_max,
    output logic signed [swmm_pkg::SUM_W-1:0]    sum,
    output logic                                 more_reads
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic signed [swmm_pkg::SAMPLE_W-1:0] store [DEPTH];
    logic signed [swmm_pkg::SAMPLE_W-1:0] rd_data_reg;

    logic [AW-1:0]                        wr_slot_reg;
    logic [AW-1:0]                        rd_ptr_reg;
    logic [swmm_pkg::CNT_W-1:0]           fill_reg;
    logic [swmm_pkg::CNT_W-1:0]           rem_reg;
    logic signed [swmm_pkg::SAMPLE_W-1:0] min_reg;
    logic signed [swmm_pkg::SAMPLE_W-1:0] max_reg;
    logic signed [swmm_pkg::SUM_W-1:0]    sum_reg;

    logic [swmm_pkg::CNT_W:0]             fill_inc;
    logic [swmm_pkg::CNT_W-1:0]           fill_next;
    logic                                 step_ptr;

    assign fill_inc   = {1'b0, fill_reg} + 1'b1;
    assign fill_next  = (fill_inc > {1'b0, win}) ? win : fill_inc[swmm_pkg::CNT_W-1:0];
    assign more_reads = (rem_reg != '0);
    assign step_ptr   = ctl.rd_issue && more_reads;

    // Store write on transfer, registered read during the scan
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            store[wr_slot_reg] <= sample;
        end
        if (ctl.rd_issue) begin
            rd_data_reg <= store[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg <= '0;
            fill_reg    <= '0;
            rem_reg     <= '0;
            rd_ptr_reg  <= '0;
        end else begin
            if (in_fire) begin
                wr_slot_reg <= (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
                fill_reg    <= fill_next;
                rem_reg     <= fill_next;
                rd_ptr_reg  <= wr_slot_reg;
            end else if (step_ptr) begin
                // walk back from the newest sample
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - 1'b1;
                rem_reg    <= rem_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            min_reg <= sample;
            max_reg <= sample;
            sum_reg <= '0;
        end else if (ctl.acc) begin
            if (rd_data_reg < min_reg) begin
                min_reg <= rd_data_reg;
            end
            if (rd_data_reg > max_reg) begin
                max_reg <= rd_data_reg;
            end
            sum_reg <= sum_reg + swmm_pkg::SUM_W'(rd_data_reg);
        end
    end

    assign fill    = fill_reg;
    assign win_min = min_reg;
    assign win_max = max_reg;
    assign sum     = sum_reg;

endmodule

// ===== src/swmm_div.sv =====
// Restoring divider, one quotient bit per cycle while step is high, truncating toward zero.
module swmm_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 init,
    input  logic                                 step,
    input  logic signed [swmm_pkg::SUM_W-1:0]    dividend,
    input  logic [swmm_pkg::CNT_W-1:0]           divisor,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] quotient,
    output logic                                 more
);

    logic [swmm_pkg::SUM_W-1:0]     q_reg;
    logic [swmm_pkg::CNT_W-1:0]     rem_reg;
    logic [swmm_pkg::CNT_W-1:0]     dvs_reg;
    logic                           neg_reg;
    logic [swmm_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic [swmm_pkg::SUM_W-1:0]     mag;
    logic [swmm_pkg::CNT_W:0]       trial;
    logic                           ge;
    logic [swmm_pkg::SAMPLE_W-1:0]  q_low;

    assign mag   = dividend[swmm_pkg::SUM_W-1] ? swmm_pkg::SUM_W'(-dividend)
                                               : swmm_pkg::SUM_W'(dividend);
    assign trial = {rem_reg, q_reg[swmm_pkg::SUM_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign more  = (cnt_reg != swmm_pkg::DIV_CNT_W'(1));
    assign q_low = q_reg[swmm_pkg::SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (init) begin
            cnt_reg <= swmm_pkg::DIV_CNT_W'(swmm_pkg::DIV_STEPS);
        end else if (step) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            q_reg   <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[swmm_pkg::SUM_W-1];
        end else if (step) begin
            rem_reg <= ge ? swmm_pkg::CNT_W'(trial - {1'b0, dvs_reg})
                          : swmm_pkg::CNT_W'(trial);
            q_reg   <= {q_reg[swmm_pkg::SUM_W-2:0], ge};
        end
    end

    assign quotient = neg_reg ? $signed(-q_low) : $signed(q_low);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sliding-window minimum, maximum and mean block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = swmm_pkg::SAMPLE_W;
    localparam int CNT_W    = swmm_pkg::CNT_W;

    localparam int unsigned STORE_DEPTH = 1024;
    localparam longint TIMEOUT_NS = 64'd60_000_000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] mean;
        logic [CNT_W-1:0]           count;
    } window_stats_t;

    logic                       aclk;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]           cfg_wr_data = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample    = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_window_min;
    logic signed [SAMPLE_W-1:0] m_window_max;
    logic signed [SAMPLE_W-1:0] m_window_mean;
    logic [CNT_W-1:0]           m_held_count;

    // Shadow of the block's ring store and window state
    logic signed [SAMPLE_W-1:0] ring_copy [STORE_DEPTH];
    int unsigned                ring_next      = 0;
    int unsigned                ring_held      = 0;
    logic [CNT_W-1:0]           window_setting = swmm_pkg::WINDOW_RESET;

    window_stats_t pending_stats [$];
    int unsigned   mismatch_count = 0;
    int unsigned   samples_sent   = 0;
    int unsigned   results_seen   = 0;
    int unsigned   window_writes  = 0;
    int unsigned   burst_left     = 0;

    logic [15:0] ready_pattern;
    int unsigned pattern_age;

    sliding_window_min_max_mean #(
        .DEPTH(STORE_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_window_min  (m_window_min),
        .m_window_max  (m_window_max),
        .m_window_mean (m_window_mean),
        .m_held_count  (m_held_count)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("sliding_window_min_max_mean test failed");
        $finish;
    end

    // Store the sample, update the held count and scan the newest held entries.
    function automatic void compute_window_stats(input logic signed [SAMPLE_W-1:0] value);
        int unsigned   eff;
        int unsigned   slot;
        longint        total;
        window_stats_t st;
        eff = (window_setting == 0) ? 1 :
              ((window_setting > STORE_DEPTH) ? STORE_DEPTH : int'(window_setting));
        ring_copy[ring_next] = value;
        ring_next = (ring_next + 1) % STORE_DEPTH;
        if (ring_held < eff) begin
            ring_held++;
        end else begin
            ring_held = eff;
        end
        st.lo = value;
        st.hi = value;
        total = 0;
        for (int unsigned k = 0; k < ring_held; k++) begin
            slot = (ring_next + STORE_DEPTH - 1 - k) % STORE_DEPTH;
            total += longint'(ring_copy[slot]);
            if (ring_copy[slot] < st.lo) st.lo = ring_copy[slot];
            if (ring_copy[slot] > st.hi) st.hi = ring_copy[slot];
        end
        st.mean  = SAMPLE_W'(total / longint'(ring_held));
        st.count = CNT_W'(ring_held);
        pending_stats.push_back(st);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2:    return SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        compute_window_stats(value);
        s_valid  <= 1'b1;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
        // End the burst with a gap, otherwise keep valid high for the next transfer
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(30, 120)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                       $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_results_idle();
        s_valid <= 1'b0;
        wait (pending_stats.size() == 0);
        @(posedge aclk);
    endtask

    // Call only while no result is outstanding.
    task automatic set_window(input logic [CNT_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        window_setting  = len;
        window_writes++;
    endtask

    task automatic test_reset_window();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(-SAMPLE_W'(1));
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_MAX);
        send_sample(-SAMPLE_W'(256));
        wait_results_idle();
    endtask

    task automatic test_window_zero();
        set_window('0);
        send_sample(SAMPLE_W'(5));
        send_sample(-SAMPLE_W'(3));
        send_sample(SAMPLE_MIN);
        wait_results_idle();
    endtask

    task automatic test_window_shrink_grow();
        set_window(CNT_W'(5));
        send_sample(-SAMPLE_W'(7));
        send_sample(SAMPLE_W'(3));
        send_sample(SAMPLE_W'(100));
        send_sample(-SAMPLE_W'(100));
        send_sample(SAMPLE_W'(9));
        send_sample(SAMPLE_W'(2));
        wait_results_idle();
        // Shrink while full: the oldest samples must drop at the next transfer
        set_window(CNT_W'(2));
        send_sample(-SAMPLE_W'(4));
        send_sample(-SAMPLE_W'(9));
        wait_results_idle();
        // Grow again: only new samples refill the window
        set_window(CNT_W'(4));
        send_sample(SAMPLE_W'(11));
        send_sample(-SAMPLE_W'(13));
        send_sample(SAMPLE_W'(1));
        wait_results_idle();
    endtask

    task automatic test_random_windows();
        int unsigned      sent;
        int unsigned      phase_len;
        logic [CNT_W-1:0] len;
        sent = 0;
        while (sent < 370) begin
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = CNT_W'(1);
                2:       len = CNT_W'($urandom_range(STORE_DEPTH + 1, swmm_pkg::CNT_MAX));
                3:       len = CNT_W'(STORE_DEPTH);
                default: len = CNT_W'($urandom_range(2, 48));
            endcase
            set_window(len);
            phase_len = $urandom_range(8, 50);
            repeat (phase_len) send_sample(random_sample());
            sent += phase_len;
            wait_results_idle();
        end
    endtask

    task automatic test_depth_saturation();
        // Widest setting caps at the store depth; keep it long enough to hold many samples
        set_window(swmm_pkg::CNT_MAX);
        repeat (120) send_sample(random_sample());
        wait_results_idle();
        set_window(CNT_W'(3));
        repeat (4) send_sample(random_sample());
        wait_results_idle();
        set_window(CNT_W'(STORE_DEPTH));
        repeat (6) send_sample(random_sample());
        wait_results_idle();
    endtask

    always @(posedge aclk) begin : collect_results
        window_stats_t exp_stats;
        if (!aresetn) begin
            m_ready       <= 1'b0;
            ready_pattern <= '1;
            pattern_age   <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_stats.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    mismatch_count++;
                end else begin
                    exp_stats = pending_stats.pop_front();
                    if (m_window_min !== exp_stats.lo) begin
                        $error("window_min: expected %0d, got %0d", exp_stats.lo, m_window_min);
                        mismatch_count++;
                    end
                    if (m_window_max !== exp_stats.hi) begin
                        $error("window_max: expected %0d, got %0d", exp_stats.hi, m_window_max);
                        mismatch_count++;
                    end
                    if (m_window_mean !== exp_stats.mean) begin
                        $error("window_mean: expected %0d, got %0d",
                               exp_stats.mean, m_window_mean);
                        mismatch_count++;
                    end
                    if (m_held_count !== exp_stats.count) begin
                        $error("held_count: expected %0d, got %0d",
                               exp_stats.count, m_held_count);
                        mismatch_count++;
                    end
                end
            end
            // Rotate the stall pattern, reload it now and then
            if (pattern_age == 0) begin
                ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                pattern_age   <= $urandom_range(20, 200);
            end else begin
                ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
                pattern_age   <= pattern_age - 1;
            end
            m_ready <= ready_pattern[15];
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_window();
        test_window_zero();
        test_window_shrink_grow();
        test_random_windows();
        test_depth_saturation();
        wait_results_idle();
        repeat (1100) @(posedge aclk);
        $display("Sent %0d samples, checked %0d results across %0d window writes,",
                 samples_sent, results_seen, window_writes);
        $display("including windows 0, 1, 1024 and 2047, shrink and regrow, and long windows.");
        if (mismatch_count == 0 && pending_stats.size() == 0) begin
            $display("sliding_window_min_max_mean test passed");
        end else begin
            $display("sliding_window_min_max_mean test failed");
        end
        $finish;
    end

endmodule

// ===== sliding_window_min_max_mean.f =====
+incdir+src
src/swmm_pkg.sv
src/swmm_seq.sv
src/swmm_scan.sv
src/swmm_div.sv
src/sliding_window_min_max_mean.sv
tb/testbench.sv
